// ===== rtl/prt_pkg.sv =====
// Shared types, codes and constants for the prescaled timer with reload.
// Used by every module of the block but prt_checker; depends on nothing.

package prt_pkg;

    // Item opcodes
    localparam logic [1:0] OP_ADVANCE   = 2'd0;
    localparam logic [1:0] OP_WRITE_CNT = 2'd1;
    localparam logic [1:0] OP_CLEAR_DIV = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TIMER_CONTROL = 1'b0;
    localparam logic CFG_RELOAD_VALUE  = 1'b1;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CYC_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int CTL_W    = 3;
    localparam int ACCUM_W  = 9;
    localparam int CD_W     = 12;
    localparam int PERIOD_W = 11;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Divider steps once the accumulator reaches this
    localparam logic [ACCUM_W-1:0] DIV_STEP = 9'h0FF;
    // Floor of the countdown
    localparam logic [CD_W-1:0] CD_FLOOR = 12'h800;
    // Countdown after reset: period of select 0
    localparam logic [CD_W-1:0] CD_RESET = 12'd1024;

    localparam int CTL_ENABLE_BIT = 2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [CYC_W-1:0]  elapsed_cycles;
        logic [BYTE_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] counter_value;
        logic [BYTE_W-1:0] divider_value;
        logic              timer_irq;
    } t_result;

    function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] sel);
        logic [PERIOD_W-1:0] p;
        case (sel)
            2'd0:    p = 11'd1024;
            2'd1:    p = 11'd16;
            2'd2:    p = 11'd64;
            default: p = 11'd256;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/prt_in_stage.sv =====
// Input register of the timer: captures one item from the slave stream.
// Depends on prt_pkg for the item type.

module prt_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  prt_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output prt_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    prt_pkg::t_item r_item;

    // Take a new transfer when empty or when the held item leaves in the same cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/prt_core.sv =====
// Timer state, configuration registers and the per-item update.
// Depends on prt_pkg for types, opcodes and the period table.

module prt_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  prt_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    output prt_pkg::t_result o_result
);

    localparam int CW = prt_pkg::CD_W + 1;

    logic [prt_pkg::BYTE_W-1:0]  r_counter,  n_counter;
    logic [prt_pkg::BYTE_W-1:0]  r_divider,  n_divider;
    logic [prt_pkg::ACCUM_W-1:0] r_accum,    n_accum;
    logic [prt_pkg::CD_W-1:0]    r_cd,       n_cd;
    logic                        r_pending,  n_pending;
    logic [prt_pkg::CTL_W-1:0]   r_ctl,      n_ctl;
    logic [prt_pkg::BYTE_W-1:0]  r_reload,   n_reload;

    logic [prt_pkg::BYTE_W-1:0]  cnt_a;
    logic [prt_pkg::ACCUM_W-1:0] acc_sum;
    logic [CW-1:0]               cd_sub;
    logic [CW-1:0]               cd_new;
    logic                        irq;

    always_comb begin
        n_counter = r_counter;
        n_divider = r_divider;
        n_accum   = r_accum;
        n_cd      = r_cd;
        n_pending = r_pending;
        n_ctl     = r_ctl;
        n_reload  = r_reload;
        irq       = 1'b0;
        cnt_a     = r_counter;
        acc_sum   = r_accum + {3'b000, i_item.elapsed_cycles};
        cd_sub    = {r_cd[prt_pkg::CD_W-1], r_cd} - {7'b0, i_item.elapsed_cycles};
        cd_new    = cd_sub + {2'b00, prt_pkg::period_of(r_ctl[1:0])};

        if (i_fire) begin
            case (i_item.opcode)
                prt_pkg::OP_ADVANCE: begin
                    // Delayed overflow: fire only if the counter stayed at zero
                    if (r_counter == '0 && r_pending) begin
                        irq   = 1'b1;
                        cnt_a = r_reload;
                    end
                    n_counter = cnt_a;
                    n_pending = 1'b0;

                    if (acc_sum >= prt_pkg::DIV_STEP) begin
                        n_accum   = '0;
                        n_divider = r_divider + 8'd1;
                    end else begin
                        n_accum = acc_sum;
                    end

                    if (r_ctl[prt_pkg::CTL_ENABLE_BIT]) begin
                        if (cd_sub[CW-1] || cd_sub == '0) begin
                            if (cnt_a == 8'hFF) begin
                                n_pending = 1'b1;
                                n_counter = '0;
                            end else begin
                                n_counter = cnt_a + 8'd1;
                            end
                            // Clamp at the floor of the 12-bit range
                            if (cd_new[CW-1] && !cd_new[CW-2]) begin
                                n_cd = prt_pkg::CD_FLOOR;
                            end else begin
                                n_cd = cd_new[prt_pkg::CD_W-1:0];
                            end
                        end else begin
                            n_cd = cd_sub[prt_pkg::CD_W-1:0];
                        end
                    end
                end
                prt_pkg::OP_WRITE_CNT: begin
                    n_counter = i_item.write_data;
                end
                prt_pkg::OP_CLEAR_DIV: begin
                    n_divider = '0;
                end
                default: begin
                end
            endcase
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                prt_pkg::CFG_TIMER_CONTROL: begin
                    n_ctl = i_cfg_data[prt_pkg::CTL_W-1:0];
                    // New clock select restarts the countdown
                    if (i_cfg_data[1:0] != r_ctl[1:0]) begin
                        n_cd = {1'b0, prt_pkg::period_of(i_cfg_data[1:0])};
                    end
                end
                prt_pkg::CFG_RELOAD_VALUE: begin
                    n_reload = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_divider <= '0;
            r_accum   <= '0;
            r_cd      <= prt_pkg::CD_RESET;
            r_pending <= 1'b0;
            r_ctl     <= '0;
            r_reload  <= '0;
        end else begin
            r_counter <= n_counter;
            r_divider <= n_divider;
            r_accum   <= n_accum;
            r_cd      <= n_cd;
            r_pending <= n_pending;
            r_ctl     <= n_ctl;
            r_reload  <= n_reload;
        end
    end

    assign o_result.counter_value = n_counter;
    assign o_result.divider_value = n_divider;
    assign o_result.timer_irq     = irq;

endmodule

// ===== rtl/prt_out_stage.sv =====
// Result register of the timer: holds one result for the master stream.
// Depends on prt_pkg for the result type.

module prt_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  prt_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output prt_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    prt_pkg::t_result r_result;

    // Free when empty or when the held result transfers this cycle
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/prescaled_timer_with_reload_top.sv =====
// Top level of the prescaled timer with reload (divider, counter, reload, control).
// Depends on prt_pkg, prt_in_stage, prt_core and prt_out_stage.
//
// Usage:
//   Slave stream carries one item per transfer: tuser is the opcode (advance
//   time, write counter, clear divider), tdata the cycle count and write data.
//   Master stream returns one result per item: counter, divider and the
//   timer interrupt flag.
//   Configuration channel writes the control register (index 0) and the
//   reload value (index 1); write it only while no item is in flight.
//   A result is offered from the output register after its item passes the
//   input register and prt_core. One item per cycle while the master does not
//   stall, set by the state update in prt_core that every item passes through.
//   A stalled master holds its result; the input register still takes one
//   more item, then o_s_tready drops until the master drains.
//   Reset clears counter, divider, accumulator, pending flag and registers,
//   and loads the countdown with the period of clock select 0; both streams empty.

module prescaled_timer_with_reload_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [5:0] elapsed_cycles, [13:6] write_data, [15:14] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] counter_value, [15:8] divider_value,
                                     // [16] timer_irq, [23:17] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    prt_pkg::t_item   in_item;
    prt_pkg::t_item   held_item;
    prt_pkg::t_result core_result;
    prt_pkg::t_result out_result;
    logic             held_valid;
    logic             out_can_load;
    logic             fire;
    logic             cfg_we;

    assign in_item.opcode         = i_s_tuser;
    assign in_item.elapsed_cycles = i_s_tdata[5:0];
    assign in_item.write_data     = i_s_tdata[13:6];

    assign fire        = held_valid && out_can_load;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    prt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (out_can_load),
        .o_item  (held_item)
    );

    prt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (core_result)
    );

    prt_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (out_result)
    );

    assign o_m_tdata = {7'b0, out_result.timer_irq, out_result.divider_value,
                        out_result.counter_value};

endmodule

// ===== rtl/prt_checker.sv =====
// Port-level checks for the prescaled timer with reload, bound to the top level.
// Depends only on the top level's ports.

module prt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    logic       r_have_prev;
    logic [7:0] r_prev_cnt;
    logic [7:0] r_prev_div;
    logic       out_xfer;

    assign out_xfer = o_m_tvalid && i_m_tready;

    // Track the last transferred result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (out_xfer) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_prev_cnt <= o_m_tdata[7:0];
            r_prev_div <= o_m_tdata[15:8];
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

    a_divider_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_have_prev |->
            (o_m_tdata[15:8] == r_prev_div) ||
            (o_m_tdata[15:8] == r_prev_div + 8'd1) ||
            (o_m_tdata[15:8] == 8'd0))
        else $error("divider jumped between results");

    a_irq_after_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_m_tdata[16] |-> r_have_prev && r_prev_cnt == 8'd0)
        else $error("interrupt without counter held at zero");

endmodule

bind prescaled_timer_with_reload_top prt_checker u_prt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
